[src/gpp_pkg.sv]
// Shared types, constants and constant tables for the genotype posterior block.
// No dependencies.
`default_nettype none
package gpp_pkg;

   localparam int MAX_VARIANTS = 4096;
   localparam int MAX_POPS     = 8;
   localparam int VAR_W        = 12;
   localparam int POP_W        = 3;
   localparam int LN_CELLS     = 16;
   localparam int POW_CELLS    = 16;

   localparam logic [15:0] LN2_Q16   = 16'd45426;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_GENO = 2'd1;
   localparam logic [1:0] CMD_END  = 2'd2;

   localparam logic [1:0] GT_HOM_REF = 2'd0;
   localparam logic [1:0] GT_HET     = 2'd1;
   localparam logic [1:0] GT_HOM_ALT = 2'd2;
   localparam logic [1:0] GT_MISSING = 2'd3;

   localparam logic CSR_MIN_FREQ    = 1'b0;
   localparam logic CSR_POPS_IN_USE = 1'b1;

   // word moving down the log chain: two lanes, f and 1-f
   typedef struct packed {
      logic             v;
      logic [POP_W-1:0] pop;
      logic [15:0]      mf;
      logic [15:0]      mq;
      logic [15:0]      ff;
      logic [15:0]      fq;
      logic [3:0]       ef;
      logic [3:0]       eq;
   } ln_token_type;

   // word moving down the power chain
   typedef struct packed {
      logic             v;
      logic [POP_W-1:0] pop;
      logic [31:0]      w;
      logic [15:0]      r;
      logic [4:0]       k;
      logic             z;
   } wt_token_type;

   typedef logic [31:0] pow_arr_type [POW_CELLS];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = v;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > x) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Q0.31 factors 2^(-2^-i), i = 1..16, by repeated square roots
   function automatic pow_arr_type make_pow();
      pow_arr_type t;
      logic [63:0] p;
      p = isqrt64(64'd1 << 61);
      t[0] = p[31:0];
      for (int j = 1; j < POW_CELLS; j++) begin
         p = isqrt64(p << 31);
         t[j] = p[31:0];
      end
      return t;
   endfunction

   localparam pow_arr_type POW_TAB = make_pow();

endpackage
`default_nettype wire

[src/gpp_ln_cell.sv]
// One squaring step of the log2 chain, two lanes side by side.
// Depends on gpp_pkg.
`default_nettype none
module gpp_ln_cell
   import gpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ln_token_type tok_in,
   output ln_token_type      tok_out
);

   ln_token_type tok_ff, tok_in_nxt;
   logic [31:0]  pf, pq;

   always_comb begin
      tok_in_nxt = tok_in;
      pf = tok_in.mf * tok_in.mf;
      pq = tok_in.mq * tok_in.mq;
      if (pf[31]) begin
         tok_in_nxt.mf = pf[31:16];
         tok_in_nxt.ff = {tok_in.ff[14:0], 1'b1};
      end else begin
         tok_in_nxt.mf = pf[30:15];
         tok_in_nxt.ff = {tok_in.ff[14:0], 1'b0};
      end
      if (pq[31]) begin
         tok_in_nxt.mq = pq[31:16];
         tok_in_nxt.fq = {tok_in.fq[14:0], 1'b1};
      end else begin
         tok_in_nxt.mq = pq[30:15];
         tok_in_nxt.fq = {tok_in.fq[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) tok_ff <= '0;
      else       tok_ff <= tok_in_nxt;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

[src/gpp_pow_cell.sv]
// One step of the weight chain: multiplies by a Q0.31 factor when the top
// fraction bit is set. Depends on gpp_pkg.
`default_nettype none
module gpp_pow_cell
   import gpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [31:0]  factor,
   input  wire wt_token_type tok_in,
   output wt_token_type      tok_out
);

   wt_token_type tok_ff, tok_in_nxt;
   logic [63:0]  prod;

   always_comb begin
      tok_in_nxt = tok_in;
      prod = 64'(tok_in.w) * 64'(factor);
      if (tok_in.r[15]) tok_in_nxt.w = prod[62:31];
      tok_in_nxt.r = {tok_in.r[14:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) tok_ff <= '0;
      else       tok_ff <= tok_in_nxt;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

[src/gpp_div.sv]
// Restoring divider, one quotient bit a cycle, 17-bit quotient.
// Depends on gpp_pkg.
`default_nettype none
module gpp_div
   import gpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] num,
   input  wire logic [34:0] den,
   output logic             done,
   output logic [16:0]      quot
);

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [34:0] rem_ff, den_ff;
   logic [16:0] nl_ff, q_ff;
   logic [35:0] r2;

   assign r2 = {rem_ff, nl_ff[16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 35'(num[47:17]);
         nl_ff  <= num[16:0];
         den_ff <= den;
         q_ff   <= 17'd0;
         cnt_ff <= 5'd17;
      end else if (busy_ff) begin
         if (r2 >= {1'b0, den_ff}) begin
            rem_ff <= 35'(r2 - {1'b0, den_ff});
            q_ff   <= {q_ff[15:0], 1'b1};
         end else begin
            rem_ff <= r2[34:0];
            q_ff   <= {q_ff[15:0], 1'b0};
         end
         nl_ff  <= {nl_ff[15:0], 1'b0};
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

[src/genotype_population_posterior_top.sv]
// Top level: frequency table, log chain, accumulators, weight chain, divider.
// Depends on gpp_pkg, gpp_ln_cell, gpp_pow_cell, gpp_div.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser cmd; tdata var, pop, freq, bad, genotype
//  rsp     | out | rsp_tvalid/tready  | tuser is_best; tlast last; tdata pop, post, sites
//  csr     | in  | csr_we             | csr_addr index, csr_wdata value
//
// Load: one table write. Genotype: flag read, 8 table reads, 16-cell log chain, 3
// term stages; a missing genotype or a bad variant ends after the flag read. End:
// max scan and weight pass over the n pops, the 16-cell weight chain, then the
// bit-serial divider per pop, then one result word per cycle while rsp is not stalled.
// Synchronous active-high reset clears accumulators and control; table
// contents are kept. A stalled rsp word holds; input is taken only when idle.
`default_nettype none
module genotype_population_posterior_top
   import gpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // variant_index, pop_index, freq, bad_flag, genotype
   input  wire logic [1:0]  req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // out_pop, posterior, usable_sites
   output logic             rsp_tuser,  // is_best
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [14:0] csr_wdata
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FLAG   = 4'd1;
   localparam logic [3:0] S_ISSUE  = 4'd2;
   localparam logic [3:0] S_DRAIN  = 4'd3;
   localparam logic [3:0] S_MAX    = 4'd4;
   localparam logic [3:0] S_WISSUE = 4'd5;
   localparam logic [3:0] S_WDRAIN = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_DIVW   = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   function automatic logic [3:0] lod16(input logic [15:0] x);
      logic [3:0] e;
      e = 4'd0;
      for (int j = 0; j < 16; j++) begin
         if (x[j]) e = 4'(j);
      end
      return e;
   endfunction

   // input fields
   logic [VAR_W-1:0] in_var;
   logic [POP_W-1:0] in_pop;
   logic [15:0]      in_freq;
   logic             in_bad;
   logic [1:0]       in_gt;
   logic             req_acc;

   assign in_var  = req_tdata[11:0];
   assign in_pop  = req_tdata[14:12];
   assign in_freq = req_tdata[30:15];
   assign in_bad  = req_tdata[31];
   assign in_gt   = req_tdata[33:32];

   logic [3:0]       state_ff;
   logic [14:0]      min_freq_ff;
   logic [3:0]       pops_ff;
   logic [POP_W-1:0] n_m1;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign n_m1 = (pops_ff == 4'd0) ? 3'd0 : (pops_ff > 4'd8) ? 3'd7 : 3'(pops_ff - 4'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_freq_ff <= 15'd7;
         pops_ff     <= 4'd8;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_FREQ:    min_freq_ff <= csr_wdata;
            CSR_POPS_IN_USE: pops_ff     <= csr_wdata[3:0];
            default:         ;
         endcase
      end
   end

   // table store
   logic [15:0] freq_mem [MAX_VARIANTS*MAX_POPS];
   logic        bad_mem  [MAX_VARIANTS];
   logic [15:0] freq_rd_ff;
   logic        bad_rd_ff;
   logic        load_we;
   logic [16:0] hi17;
   logic [15:0] hi16, fr_cl;

   assign load_we = req_acc && req_tuser == CMD_LOAD;
   assign hi17 = 17'h10000 - 17'(min_freq_ff);
   assign hi16 = hi17[16] ? 16'hFFFF : hi17[15:0];
   always_comb begin
      fr_cl = in_freq;
      if (fr_cl < 16'(min_freq_ff)) fr_cl = 16'(min_freq_ff);
      if (fr_cl > hi16) fr_cl = hi16;
   end

   logic [VAR_W-1:0] var_ff;
   logic [1:0]       gt_ff;
   logic [POP_W-1:0] issue_p_ff;
   logic             issuing;

   assign issuing = (state_ff == S_ISSUE);

   always_ff @(posedge clock) begin
      if (load_we) begin
         freq_mem[{in_var, in_pop}] <= fr_cl;
         bad_mem[in_var]            <= in_bad;
      end
      freq_rd_ff <= freq_mem[{var_ff, issue_p_ff}];
      bad_rd_ff  <= bad_mem[in_var];
   end

   logic             rd_v_ff;
   logic [POP_W-1:0] rd_pop_ff;

   always_ff @(posedge clock) begin
      if (reset) rd_v_ff <= 1'b0;
      else       rd_v_ff <= issuing;
      rd_pop_ff <= issue_p_ff;
   end

   // normalise f and 1-f onto Q1.15 mantissas
   ln_token_type ln_tok [LN_CELLS+1];
   logic [15:0]  f16, q16;
   logic [16:0]  q17;
   logic [3:0]   ef, eq;

   always_comb begin
      f16 = (freq_rd_ff == 16'd0) ? 16'd1 : freq_rd_ff;
      q17 = 17'h10000 - 17'(f16);
      q16 = q17[16] ? 16'hFFFF : q17[15:0];
      ef  = lod16(f16);
      eq  = lod16(q16);
      ln_tok[0].v   = rd_v_ff;
      ln_tok[0].pop = rd_pop_ff;
      ln_tok[0].mf  = f16 << (4'd15 - ef);
      ln_tok[0].mq  = q16 << (4'd15 - eq);
      ln_tok[0].ff  = 16'd0;
      ln_tok[0].fq  = 16'd0;
      ln_tok[0].ef  = ef;
      ln_tok[0].eq  = eq;
   end

   for (genvar i = 0; i < LN_CELLS; i++) begin : g_ln
      gpp_ln_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (ln_tok[i]),
         .tok_out (ln_tok[i+1])
      );
   end

   // stage A: scale log2 magnitude by ln2
   ln_token_type     lt;
   logic [20:0]      negf, negq;
   logic             pa_v_ff;
   logic [POP_W-1:0] pa_pop_ff;
   logic [36:0]      pa_pf_ff, pa_pq_ff;

   assign lt   = ln_tok[LN_CELLS];
   assign negf = {5'd16 - 5'(lt.ef), 16'd0} - 21'(lt.ff);
   assign negq = {5'd16 - 5'(lt.eq), 16'd0} - 21'(lt.fq);

   always_ff @(posedge clock) begin
      if (reset) pa_v_ff <= 1'b0;
      else       pa_v_ff <= lt.v;
      pa_pop_ff <= lt.pop;
      pa_pf_ff  <= 37'(negf) * 37'(LN2_Q16);
      pa_pq_ff  <= 37'(negq) * 37'(LN2_Q16);
   end

   // stage B: genotype term
   logic [20:0]      lf, lq;
   logic [21:0]      lsum, term;
   logic             pb_v_ff;
   logic [POP_W-1:0] pb_pop_ff;
   logic [21:0]      pb_term_ff;

   assign lf   = 21'((pa_pf_ff + 37'd32768) >> 16);
   assign lq   = 21'((pa_pq_ff + 37'd32768) >> 16);
   assign lsum = 22'(lf) + 22'(lq);

   always_comb begin
      case (gt_ff)
         GT_HOM_REF: term = {lq, 1'b0};
         GT_HOM_ALT: term = {lf, 1'b0};
         default:    term = (lsum > 22'(LN2_Q16)) ? lsum - 22'(LN2_Q16) : 22'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) pb_v_ff <= 1'b0;
      else       pb_v_ff <= pa_v_ff;
      pb_pop_ff  <= pa_pop_ff;
      pb_term_ff <= term;
   end

   // accumulators
   logic signed [39:0] acc_ff [MAX_POPS];
   logic signed [39:0] acc_rd;
   logic signed [40:0] acc_nxt;
   logic [POP_W-1:0]   scan_p_ff, acc_idx;
   logic [12:0]        site_ff;
   logic               clear_acc;

   assign acc_idx = pb_v_ff ? pb_pop_ff : scan_p_ff;
   assign acc_rd  = acc_ff[acc_idx];
   assign acc_nxt = {acc_rd[39], acc_rd} - {19'd0, pb_term_ff};

   always_ff @(posedge clock) begin
      if (reset || clear_acc) begin
         for (int p = 0; p < MAX_POPS; p++) acc_ff[p] <= 40'sd0;
      end else if (pb_v_ff) begin
         // floor at -2^39
         if (acc_nxt[40] != acc_nxt[39]) acc_ff[pb_pop_ff] <= {1'b1, 39'd0};
         else                            acc_ff[pb_pop_ff] <= acc_nxt[39:0];
      end
   end

   // weight path: d, d * log2(e), power chain
   logic signed [39:0] mx_ff;
   logic               m1_v_ff, m2_v_ff;
   logic [POP_W-1:0]   m1_pop_ff, m2_pop_ff;
   logic [39:0]        m1_d_ff;
   logic [36:0]        m2_lo_ff, m2_hi_ff;
   logic [57:0]        tsum;
   wt_token_type       wt_tok [POW_CELLS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= (state_ff == S_WISSUE);
         m2_v_ff <= m1_v_ff;
      end
      m1_pop_ff <= scan_p_ff;
      m1_d_ff   <= 40'(mx_ff - acc_rd);
      m2_pop_ff <= m1_pop_ff;
      m2_lo_ff  <= 37'(m1_d_ff[19:0]) * 37'(LOG2E_Q16);
      m2_hi_ff  <= 37'(m1_d_ff[39:20]) * 37'(LOG2E_Q16);
   end

   assign tsum = {1'b0, m2_hi_ff, 20'd0} + 58'(m2_lo_ff);

   always_comb begin
      wt_tok[0].v   = m2_v_ff;
      wt_tok[0].pop = m2_pop_ff;
      wt_tok[0].w   = 32'h8000_0000;
      wt_tok[0].r   = tsum[31:16];
      wt_tok[0].k   = tsum[36:32];
      wt_tok[0].z   = |tsum[57:37];
   end

   for (genvar i = 0; i < POW_CELLS; i++) begin : g_pow
      gpp_pow_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .factor  (POW_TAB[i]),
         .tok_in  (wt_tok[i]),
         .tok_out (wt_tok[i+1])
      );
   end

   wt_token_type wo;
   logic [31:0]  wfin;
   logic [31:0]  w_ff [MAX_POPS];
   logic [34:0]  sum_ff, sumd;
   logic         wt_busy;

   assign wo   = wt_tok[POW_CELLS];
   assign wfin = wo.z ? 32'd0 : (wo.w >> wo.k);

   always_comb begin
      wt_busy = m1_v_ff | m2_v_ff;
      for (int i = 0; i <= POW_CELLS; i++) wt_busy = wt_busy | wt_tok[i].v;
   end

   always_ff @(posedge clock) begin
      if (req_acc) sum_ff <= 35'd0;
      else if (wo.v) sum_ff <= sum_ff + 35'(wfin);
      if (wo.v) w_ff[wo.pop] <= wfin;
   end

   // divider
   logic        div_start, div_done;
   logic [16:0] div_q;
   logic [47:0] div_num;

   assign sumd      = (sum_ff == 35'd0) ? 35'd1 : sum_ff;
   assign div_num   = {w_ff[scan_p_ff], 16'd0} + 48'(sumd >> 1);
   assign div_start = (state_ff == S_DIV);

   gpp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (sumd),
      .done  (div_done),
      .quot  (div_q)
   );

   logic [16:0]      post_ff [MAX_POPS];
   logic [16:0]      best_val_ff;
   logic [POP_W-1:0] best_ff;

   // log chain busy
   logic ln_busy;
   always_comb begin
      ln_busy = rd_v_ff | pa_v_ff | pb_v_ff;
      for (int i = 0; i <= LN_CELLS; i++) ln_busy = ln_busy | ln_tok[i].v;
   end

   // output register
   logic             rsp_v_ff, rsp_best_ff, rsp_last_ff;
   logic [POP_W-1:0] rsp_pop_ff;
   logic [16:0]      rsp_post_ff;
   logic [12:0]      rsp_sites_ff;
   logic             out_load;

   assign out_load  = (state_ff == S_OUT) && (!rsp_v_ff || rsp_tready);
   assign clear_acc = out_load && scan_p_ff == n_m1;

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (out_load) rsp_v_ff <= 1'b1;
      else if (rsp_tready) rsp_v_ff <= 1'b0;
      if (out_load) begin
         rsp_pop_ff   <= scan_p_ff;
         rsp_post_ff  <= post_ff[scan_p_ff];
         rsp_best_ff  <= (scan_p_ff == best_ff);
         rsp_sites_ff <= site_ff;
         rsp_last_ff  <= (scan_p_ff == n_m1);
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {7'd0, rsp_sites_ff, rsp_post_ff, rsp_pop_ff};
   assign rsp_tuser  = rsp_best_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         site_ff  <= 13'd0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  case (req_tuser)
                     CMD_GENO: state_ff <= S_FLAG;
                     CMD_END:  state_ff <= S_MAX;
                     default:  ;
                  endcase
               end
            end
            S_FLAG: begin
               if (!bad_rd_ff && gt_ff != GT_MISSING) begin
                  state_ff <= S_ISSUE;
                  if (site_ff != 13'h1FFF) site_ff <= site_ff + 13'd1;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_ISSUE:  if (issue_p_ff == 3'(MAX_POPS - 1)) state_ff <= S_DRAIN;
            S_DRAIN:  if (!ln_busy) state_ff <= S_IDLE;
            S_MAX:    if (scan_p_ff == n_m1) state_ff <= S_WISSUE;
            S_WISSUE: if (scan_p_ff == n_m1) state_ff <= S_WDRAIN;
            S_WDRAIN: if (!wt_busy) state_ff <= S_DIV;
            S_DIV:    state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_done) state_ff <= (scan_p_ff == n_m1) ? S_OUT : S_DIV;
            end
            S_OUT: begin
               if (clear_acc) begin
                  state_ff <= S_IDLE;
                  site_ff  <= 13'd0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         var_ff     <= in_var;
         gt_ff      <= in_gt;
         issue_p_ff <= '0;
         scan_p_ff  <= '0;
      end
      if (issuing) issue_p_ff <= issue_p_ff + 3'd1;
      case (state_ff)
         S_MAX: begin
            if (scan_p_ff == 3'd0 || acc_rd > mx_ff) mx_ff <= acc_rd;
            scan_p_ff <= (scan_p_ff == n_m1) ? 3'd0 : scan_p_ff + 3'd1;
         end
         S_WISSUE: scan_p_ff <= (scan_p_ff == n_m1) ? 3'd0 : scan_p_ff + 3'd1;
         S_DIVW: begin
            if (div_done) begin
               post_ff[scan_p_ff] <= div_q;
               if (scan_p_ff == 3'd0 || div_q > best_val_ff) begin
                  best_ff     <= scan_p_ff;
                  best_val_ff <= div_q;
               end
               scan_p_ff <= (scan_p_ff == n_m1) ? 3'd0 : scan_p_ff + 3'd1;
            end
         end
         S_OUT: if (out_load) scan_p_ff <= scan_p_ff + 3'd1;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

[src/gpp_checker.sv]
// Port-level checks on the genotype posterior top, bound to it below.
// Depends on genotype_population_posterior_top.
`default_nettype none
module gpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   a_post_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:3] <= 17'd65536)
      else $error("posterior above one");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("word after end of run");

   a_busy_when_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken mid run");

   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tuser, rsp_tlast, rsp_tdata}))
      else $error("unknown bits in rsp word");

endmodule

bind genotype_population_posterior_top gpp_checker u_gpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
